// ===== design/odo_pkg.sv =====
// Shared constants, tables and codes for the differential-drive odometry block
package odo_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int TICK_BITS_DEF    = 16;

	localparam int SCALE_W = 24;
	localparam int US_W    = 20;
	localparam int POS_W   = 32;
	localparam int HEAD_W  = 25;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SCALE = 2'd2;

	localparam logic [SCALE_W-1:0] LEFT_SCALE_RST  = 24'd33554;
	localparam logic [SCALE_W-1:0] RIGHT_SCALE_RST = 24'd33554;
	localparam logic [SCALE_W-1:0] ANGLE_SCALE_RST = 24'd167772;

	localparam int US_PER_S_W = 20;
	localparam logic [US_PER_S_W-1:0] US_PER_S = 20'd1000000;
	localparam int SPEED_SHIFT = 8;
	localparam int QUO_W       = 31;

	localparam int POS_SHIFT  = 39;
	localparam int HEAD_SHIFT = 8;
	localparam int HEAD180    = 11796480;
	localparam int HEAD360    = 23592960;

	localparam int CORDIC_XW = 34;
	localparam int CORDIC_ZW = 54;
	localparam logic [CORDIC_XW-1:0] CORDIC_GAIN = 34'd652032874;
	localparam int ZSCALE_W = 28;
	localparam logic [ZSCALE_W-1:0] ZSCALE = 28'd244140625;
	localparam logic signed [CORDIC_ZW-1:0] DEG90  = 54'sd1440000000000000;
	localparam logic signed [CORDIC_ZW-1:0] DEG180 = 54'sd2880000000000000;

	localparam int ATAN_N = 32;
	localparam int ATAN_W = 46;
	typedef logic [ATAN_W-1:0] atan_t;
	localparam atan_t ATAN_PDEG [ATAN_N] = '{
		46'd45000000000000, 46'd26565051177078, 46'd14036243467926, 46'd7125016348902,
		46'd3576334374997,  46'd1789910608246,  46'd895173710211,   46'd447614170861,
		46'd223810500369,   46'd111905677066,   46'd55952891894,    46'd27976452617,
		46'd13988227142,    46'd6994113675,     46'd3497056851,     46'd1748528427,
		46'd874264214,      46'd437132107,      46'd218566053,      46'd109283027,
		46'd54641513,       46'd27320757,       46'd13660378,       46'd6830189,
		46'd3415095,        46'd1707547,        46'd853774,         46'd426887,
		46'd213443,         46'd106722,         46'd53361,          46'd26680
	};

endpackage

// ===== design/odo_channels.sv =====
// Sample and pose channel interfaces
interface odo_in_if #(parameter int TICK_BITS = odo_pkg::TICK_BITS_DEF);
	import odo_pkg::*;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic signed [TICK_BITS-1:0] left_ticks;
	logic signed [TICK_BITS-1:0] right_ticks;
	logic [US_W-1:0]             elapsed_us;
	logic signed [POS_W-1:0]     pose_x;
	logic signed [POS_W-1:0]     pose_y;
	logic signed [HEAD_W-1:0]    pose_heading;

	modport source (output valid, op, left_ticks, right_ticks, elapsed_us, pose_x, pose_y,
		pose_heading, input ready);
	modport sink (input valid, op, left_ticks, right_ticks, elapsed_us, pose_x, pose_y,
		pose_heading, output ready);
endinterface

interface odo_out_if;
	import odo_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [HEAD_W-1:0] heading;
	logic signed [POS_W-1:0]  left_speed;
	logic signed [POS_W-1:0]  right_speed;
	logic signed [POS_W-1:0]  total_left;
	logic signed [POS_W-1:0]  total_right;

	modport source (output valid, pos_x, pos_y, heading, left_speed, right_speed, total_left,
		total_right, input ready);
	modport sink (input valid, pos_x, pos_y, heading, left_speed, right_speed, total_left,
		total_right, output ready);
endinterface

// ===== design/odo_mul_ser.sv =====
// Bit-serial shift-add unsigned multiplier, one multiplier bit per cycle
module odo_mul_ser #(
	parameter int A_W = 16,
	parameter int B_W = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               busy,
	output logic [A_W+B_W-1:0] prod
);
	localparam int CW = $clog2(B_W);

	logic [A_W-1:0] a_q;
	logic [A_W-1:0] acc_q;
	logic [B_W-1:0] lo_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic [A_W:0]   sum;

	assign sum  = {1'b0, acc_q} + {1'b0, (lo_q[0] ? a_q : '0)};
	assign busy = busy_q;
	assign prod = {acc_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(B_W-1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			acc_q <= '0;
			lo_q  <= b;
		end else if (busy_q) begin
			acc_q <= sum[A_W:1];
			lo_q  <= {sum[0], lo_q[B_W-1:1]};
		end
	end

endmodule

// ===== design/odo_div_ser.sv =====
// Restoring divider for wheel speed, one quotient bit per cycle with overflow flag
module odo_div_ser #(
	parameter int N_W = 52
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [N_W-1:0]            num,
	input  logic [odo_pkg::US_W-1:0]  den,
	output logic                      busy,
	output logic                      ovf,
	output logic [odo_pkg::QUO_W-1:0] quo
);
	import odo_pkg::*;

	localparam int CW  = $clog2(QUO_W);
	localparam int TW  = N_W - QUO_W;
	localparam int CMW = (TW > US_W) ? TW : US_W;

	logic [US_W-1:0]  den_q;
	logic [US_W-1:0]  rem_q;
	logic [QUO_W-1:0] lo_q;
	logic [QUO_W-1:0] quo_q;
	logic             ovf_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [US_W:0]    trial;
	logic [US_W:0]    diff;
	logic             fits;

	assign trial = {rem_q, lo_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};
	assign busy  = busy_q;
	assign ovf   = ovf_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(QUO_W-1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			ovf_q <= CMW'(num[N_W-1:QUO_W]) >= CMW'(den);
			rem_q <= US_W'(num[N_W-1:QUO_W]);
			lo_q  <= num[QUO_W-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[US_W-1:0] : trial[US_W-1:0];
			lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

endmodule

// ===== design/odo_cordic.sv =====
// Iterative CORDIC rotation giving sine and cosine of the heading
module odo_cordic #(
	parameter int STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [odo_pkg::HEAD_W-1:0]    heading,
	output logic                                 busy,
	output logic signed [odo_pkg::CORDIC_XW-1:0] sn,
	output logic signed [odo_pkg::CORDIC_XW-1:0] cs
);
	import odo_pkg::*;

	localparam int XW = CORDIC_XW;
	localparam int ZW = CORDIC_ZW;
	localparam int IW = $clog2(STEPS);

	logic signed [XW-1:0] x_q;
	logic signed [XW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic                 neg_q;
	logic                 prep_q;
	logic                 busy_q;
	logic [IW-1:0]        i_q;
	logic signed [ZW-1:0] hx;
	logic signed [ZW-1:0] kx;
	logic signed [ZW-1:0] zprod;
	logic signed [ZW-1:0] step;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic [4:0]           idx;

	assign hx    = ZW'(heading);
	assign kx    = ZW'(ZSCALE);
	assign zprod = hx * kx;
	assign idx   = 5'(i_q);
	assign step  = $signed({{(ZW-ATAN_W-4){1'b0}}, ATAN_PDEG[idx], 4'b0000});
	assign xs    = x_q >>> i_q;
	assign ys    = y_q >>> i_q;
	assign busy  = busy_q;
	assign sn    = neg_q ? -y_q : y_q;
	assign cs    = neg_q ? -x_q : x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			prep_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			prep_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q && prep_q) begin
			prep_q <= 1'b0;
		end else if (busy_q) begin
			i_q <= i_q + 1'b1;
			if (i_q == IW'(STEPS-1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			z_q   <= zprod;
			x_q   <= $signed(CORDIC_GAIN);
			y_q   <= '0;
			neg_q <= 1'b0;
		end else if (busy_q && prep_q) begin
			if (z_q > DEG90) begin
				z_q   <= z_q - DEG180;
				neg_q <= 1'b1;
			end else if (z_q < -DEG90) begin
				z_q   <= z_q + DEG180;
				neg_q <= 1'b1;
			end
		end else if (busy_q) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step;
			end
		end
	end

	a_start_prep: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && prep_q && i_q == '0)
		else $error("rotation did not begin with the quadrant step");
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !prep_q && !start && i_q == IW'(STEPS-1) |=> !busy_q)
		else $error("rotation ran past its last step");
	a_prep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		prep_q |-> busy_q)
		else $error("quadrant step outside a rotation");

endmodule

// ===== design/differential_drive_odometry.sv =====
// Differential-drive odometry: an encoder sample (op 0) updates wheel speeds, tick totals,
// x, y and heading; a load-pose item (op 1) sets x, y and heading and returns zero speeds.
// Each item gives one result. A load-pose item goes from acceptance to the finish state,
// where its result is registered once the output register is free. An encoder sample
// passes through three phases before its result is registered: the three 24-bit scale
// multiplies run bit-serially alongside the CORDIC, then the 34-bit sine and cosine
// multiplies and the two speed multiplies run bit-serially, then the two restoring
// dividers give one speed bit per cycle. One item is processed at a time; the next is
// accepted from the cycle after the result is registered, while that result waits in
// the output register. A result still waiting when the next one is ready holds the
// block. Configuration writes take effect at once and must only be made while the block
// is idle.
module differential_drive_odometry #(
	parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF,
	parameter int TICK_BITS    = odo_pkg::TICK_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [odo_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [odo_pkg::SCALE_W-1:0]       cfg_data,
	odo_in_if.sink                            sample,
	odo_out_if.source                         pose
);
	import odo_pkg::*;

	localparam int T    = TICK_BITS;
	localparam int DW   = T + 1;
	localparam int PW   = T + SCALE_W;
	localparam int PHW  = DW + SCALE_W;
	localparam int SW   = PW + 2;
	localparam int XW   = CORDIC_XW;
	localparam int UPW  = PW + US_PER_S_W;
	localparam int NUMW = UPW - SPEED_SHIFT;
	localparam int PXW  = PW + XW;
	localparam int RW   = PXW - POS_SHIFT;
	localparam int SUMW = (RW + 2 > POS_W + 2) ? RW + 2 : POS_W + 2;
	localparam int DHW  = PHW - HEAD_SHIFT;
	localparam int HW   = ((DHW + 2 > HEAD_W + 2) ? DHW + 2 : HEAD_W + 2) + 1;

	localparam logic signed [SUMW-1:0] PMAX = {{(SUMW-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
	localparam logic signed [SUMW-1:0] PMIN = {{(SUMW-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};
	localparam logic signed [HW-1:0] H180 = HW'(HEAD180);
	localparam logic signed [HW-1:0] H360 = HW'(HEAD360);
	localparam logic signed [HW-1:0] HMAX = {{(HW-HEAD_W+1){1'b0}}, {(HEAD_W-1){1'b1}}};
	localparam logic signed [HW-1:0] HMIN = {{(HW-HEAD_W+1){1'b1}}, {(HEAD_W-1){1'b0}}};

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ST1  = 3'd1;
	localparam logic [2:0] S_W1   = 3'd2;
	localparam logic [2:0] S_W2   = 3'd3;
	localparam logic [2:0] S_W3   = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q;

	logic [SCALE_W-1:0] lscale_q;
	logic [SCALE_W-1:0] rscale_q;
	logic [SCALE_W-1:0] ascale_q;

	logic signed [POS_W-1:0]  x_pos_q;
	logic signed [POS_W-1:0]  y_pos_q;
	logic signed [HEAD_W-1:0] hdg_q;
	logic signed [POS_W-1:0]  ltot_q;
	logic signed [POS_W-1:0]  rtot_q;

	logic                     op_q;
	logic signed [T-1:0]      lt_q;
	logic signed [T-1:0]      rt_q;
	logic [US_W-1:0]          us_q;
	logic signed [POS_W-1:0]  px_q;
	logic signed [POS_W-1:0]  py_q;
	logic signed [HEAD_W-1:0] ph_q;

	logic                     out_valid_q;
	logic signed [POS_W-1:0]  out_x_q;
	logic signed [POS_W-1:0]  out_y_q;
	logic signed [HEAD_W-1:0] out_h_q;
	logic signed [POS_W-1:0]  out_ls_q;
	logic signed [POS_W-1:0]  out_rs_q;
	logic signed [POS_W-1:0]  out_lt_q;
	logic signed [POS_W-1:0]  out_rt_q;

	logic accept;
	logic start1;
	logic start2;
	logic start3;
	logic fin;

	logic [T-1:0]         lmag;
	logic [T-1:0]         rmag;
	logic                 lneg;
	logic                 rneg;
	logic signed [DW-1:0] dsig;
	logic [DW-1:0]        dmag;

	logic           busy_l, busy_r, busy_h, busy_c;
	logic           busy_ul, busy_ur, busy_px, busy_py;
	logic           busy_dl, busy_dr;
	logic [PW-1:0]  prod_l;
	logic [PW-1:0]  prod_r;
	logic [PHW-1:0] prod_h;
	logic [UPW-1:0] prod_ul;
	logic [UPW-1:0] prod_ur;
	logic [PXW-1:0] prod_px;
	logic [PXW-1:0] prod_py;

	logic signed [XW-1:0] sn;
	logic signed [XW-1:0] cs;
	logic [XW-1:0]        snmag;
	logic [XW-1:0]        csmag;

	logic signed [SW-1:0] dl;
	logic signed [SW-1:0] dr;
	logic signed [SW-1:0] ssum;
	logic [SW-1:0]        sabs;
	logic                 sneg;

	logic                 ovf_l, ovf_r;
	logic [QUO_W-1:0]     quo_l, quo_r;

	logic signed [SUMW-1:0] dx, dy, sum_x, sum_y;
	logic signed [POS_W-1:0] x_new, y_new;
	logic signed [HW-1:0]   dhs, hsum, h1, h2;
	logic signed [HEAD_W-1:0] h_new;
	logic signed [POS_W-1:0] ls_new, rs_new;
	logic                   us_zero;

	function automatic logic [POS_W-1:0] speed_val(input logic zero_t, input logic neg,
		input logic ov, input logic [QUO_W-1:0] q);
		priority if (zero_t) return '0;
		else if (ov) return neg ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		else return neg ? (~{1'b0, q} + 1'b1) : {1'b0, q};
	endfunction

	assign accept = sample.valid && sample.ready;
	assign sample.ready = (state_q == S_IDLE);
	assign start1 = (state_q == S_ST1);
	assign start2 = (state_q == S_W1) && !busy_l && !busy_r && !busy_h && !busy_c;
	assign start3 = (state_q == S_W2) && !busy_ul && !busy_ur && !busy_px && !busy_py;
	assign fin    = (state_q == S_FIN) && (!out_valid_q || pose.ready);

	assign lneg = lt_q[T-1];
	assign rneg = rt_q[T-1];
	assign lmag = lneg ? -lt_q : lt_q;
	assign rmag = rneg ? -rt_q : rt_q;
	assign dsig = DW'(lt_q) - DW'(rt_q);
	assign dmag = dsig[DW-1] ? -dsig : dsig;

	odo_mul_ser #(.A_W(T), .B_W(SCALE_W)) u_mul_l (
		.clk, .arst_n, .start(start1), .a(lmag), .b(lscale_q), .busy(busy_l), .prod(prod_l));
	odo_mul_ser #(.A_W(T), .B_W(SCALE_W)) u_mul_r (
		.clk, .arst_n, .start(start1), .a(rmag), .b(rscale_q), .busy(busy_r), .prod(prod_r));
	odo_mul_ser #(.A_W(DW), .B_W(SCALE_W)) u_mul_h (
		.clk, .arst_n, .start(start1), .a(dmag), .b(ascale_q), .busy(busy_h), .prod(prod_h));
	odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk, .arst_n, .start(start1), .heading(hdg_q), .busy(busy_c), .sn(sn), .cs(cs));

	assign dl    = lneg ? -SW'(prod_l) : SW'(prod_l);
	assign dr    = rneg ? -SW'(prod_r) : SW'(prod_r);
	assign ssum  = dl + dr;
	assign sneg  = ssum[SW-1];
	assign sabs  = sneg ? -ssum : ssum;
	assign snmag = sn[XW-1] ? -sn : sn;
	assign csmag = cs[XW-1] ? -cs : cs;

	odo_mul_ser #(.A_W(PW), .B_W(US_PER_S_W)) u_mul_ul (
		.clk, .arst_n, .start(start2), .a(prod_l), .b(US_PER_S), .busy(busy_ul),
		.prod(prod_ul));
	odo_mul_ser #(.A_W(PW), .B_W(US_PER_S_W)) u_mul_ur (
		.clk, .arst_n, .start(start2), .a(prod_r), .b(US_PER_S), .busy(busy_ur),
		.prod(prod_ur));
	odo_mul_ser #(.A_W(PW), .B_W(XW)) u_mul_px (
		.clk, .arst_n, .start(start2), .a(sabs[PW-1:0]), .b(snmag), .busy(busy_px),
		.prod(prod_px));
	odo_mul_ser #(.A_W(PW), .B_W(XW)) u_mul_py (
		.clk, .arst_n, .start(start2), .a(sabs[PW-1:0]), .b(csmag), .busy(busy_py),
		.prod(prod_py));

	odo_div_ser #(.N_W(NUMW)) u_div_l (
		.clk, .arst_n, .start(start3), .num(prod_ul[UPW-1:SPEED_SHIFT]), .den(us_q),
		.busy(busy_dl), .ovf(ovf_l), .quo(quo_l));
	odo_div_ser #(.N_W(NUMW)) u_div_r (
		.clk, .arst_n, .start(start3), .num(prod_ur[UPW-1:SPEED_SHIFT]), .den(us_q),
		.busy(busy_dr), .ovf(ovf_r), .quo(quo_r));

	assign dx = (sneg ^ sn[XW-1]) ? -SUMW'(prod_px[PXW-1:POS_SHIFT])
		: SUMW'(prod_px[PXW-1:POS_SHIFT]);
	assign dy = (sneg ^ cs[XW-1]) ? -SUMW'(prod_py[PXW-1:POS_SHIFT])
		: SUMW'(prod_py[PXW-1:POS_SHIFT]);
	assign sum_x = SUMW'(x_pos_q) + dx;
	assign sum_y = SUMW'(y_pos_q) + dy;
	assign x_new = (sum_x > PMAX) ? PMAX[POS_W-1:0]
		: (sum_x < PMIN) ? PMIN[POS_W-1:0] : sum_x[POS_W-1:0];
	assign y_new = (sum_y > PMAX) ? PMAX[POS_W-1:0]
		: (sum_y < PMIN) ? PMIN[POS_W-1:0] : sum_y[POS_W-1:0];

	assign dhs  = dsig[DW-1] ? -HW'(prod_h[PHW-1:HEAD_SHIFT]) : HW'(prod_h[PHW-1:HEAD_SHIFT]);
	assign hsum = HW'(hdg_q) + dhs;
	assign h1   = (hsum < -H180) ? hsum + H360 : hsum;
	assign h2   = (h1 > H180) ? h1 - H360 : h1;
	assign h_new = (h2 > HMAX) ? HMAX[HEAD_W-1:0]
		: (h2 < HMIN) ? HMIN[HEAD_W-1:0] : h2[HEAD_W-1:0];

	assign us_zero = (us_q == '0);
	assign ls_new  = speed_val(us_zero, lneg, ovf_l, quo_l);
	assign rs_new  = speed_val(us_zero, rneg, ovf_r, quo_r);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) state_q <= sample.op ? S_FIN : S_ST1;
				S_ST1:  state_q <= S_W1;
				S_W1:   if (start2) state_q <= S_W2;
				S_W2:   if (start3) state_q <= S_W3;
				S_W3:   if (!busy_dl && !busy_dr) state_q <= S_FIN;
				S_FIN:  if (fin) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lscale_q <= LEFT_SCALE_RST;
			rscale_q <= RIGHT_SCALE_RST;
			ascale_q <= ANGLE_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LEFT_SCALE:  lscale_q <= cfg_data;
				CFG_RIGHT_SCALE: rscale_q <= cfg_data;
				CFG_ANGLE_SCALE: ascale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_pos_q <= '0;
			y_pos_q <= '0;
			hdg_q   <= '0;
			ltot_q  <= '0;
			rtot_q  <= '0;
		end else if (fin) begin
			if (op_q) begin
				x_pos_q <= px_q;
				y_pos_q <= py_q;
				hdg_q   <= ph_q;
			end else begin
				x_pos_q <= x_new;
				y_pos_q <= y_new;
				hdg_q   <= h_new;
				ltot_q  <= ltot_q + POS_W'(lt_q);
				rtot_q  <= rtot_q + POS_W'(rt_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (pose.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= sample.op;
			lt_q <= sample.left_ticks;
			rt_q <= sample.right_ticks;
			us_q <= sample.elapsed_us;
			px_q <= sample.pose_x;
			py_q <= sample.pose_y;
			ph_q <= sample.pose_heading;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			if (op_q) begin
				out_x_q  <= px_q;
				out_y_q  <= py_q;
				out_h_q  <= ph_q;
				out_ls_q <= '0;
				out_rs_q <= '0;
				out_lt_q <= ltot_q;
				out_rt_q <= rtot_q;
			end else begin
				out_x_q  <= x_new;
				out_y_q  <= y_new;
				out_h_q  <= h_new;
				out_ls_q <= ls_new;
				out_rs_q <= rs_new;
				out_lt_q <= ltot_q + POS_W'(lt_q);
				out_rt_q <= rtot_q + POS_W'(rt_q);
			end
		end
	end

	assign pose.valid       = out_valid_q;
	assign pose.pos_x       = out_x_q;
	assign pose.pos_y       = out_y_q;
	assign pose.heading     = out_h_q;
	assign pose.left_speed  = out_ls_q;
	assign pose.right_speed = out_rs_q;
	assign pose.total_left  = out_lt_q;
	assign pose.total_right = out_rt_q;

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !sample.op |=> state_q == S_ST1)
		else $error("encoder sample did not start the multipliers");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && out_valid_q && !pose.ready |=> state_q == S_FIN)
		else $error("pending result overwritten");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !busy_l && !busy_c && !busy_px && !busy_dl && !busy_dr)
		else $error("arithmetic unit busy while idle");

endmodule
